@@ design/rdos_pkg.sv @@
// Shared types, codes and helpers for the relocation directory overlap scan.
package rdos_pkg;

    localparam int TypeShift  = 12;
    localparam int OffsetBits = 12;
    localparam int HeaderBytes = 8;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CLEAN     = 3'd1,
        ST_BAD_DIR   = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_BAD_BLOCK = 3'd4,
        ST_BAD_TYPE  = 3'd5,
        ST_OVERLAP   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_PAGE_LO = 3'd0,
        PH_PAGE_HI = 3'd1,
        PH_SIZE_LO = 3'd2,
        PH_SIZE_HI = 3'd3,
        PH_ENTRIES = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        REG_SAMPLE_START  = 2'd0,
        REG_SAMPLE_LENGTH = 2'd1,
        REG_DIR_ADDRESS   = 2'd2,
        REG_DIR_BYTES     = 2'd3
    } reg_index_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] page_address;
        logic [31:0] block_left;
        logic [31:0] bytes_consumed;
        status_t     final_status;
        logic        finished;
    } scan_state_t;

    typedef struct packed {
        logic [31:0] sample_start;
        logic [31:0] sample_length;
        logic [31:0] directory_address;
        logic [31:0] directory_bytes;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic        done_res;
        logic [32:0] hit_address;
    } result_t;

    typedef struct packed {
        logic       supported;
        logic [3:0] width;
    } type_info_t;

    // byte width covered by a relocation entry type
    function automatic type_info_t type_info(input logic [3:0] kind);
        type_info_t ti;
        ti = '{supported: 1'b1, width: 4'd0};
        case (kind)
            4'd0:       ti.width = 4'd0;
            4'd1, 4'd2: ti.width = 4'd2;
            4'd3:       ti.width = 4'd4;
            4'd10:      ti.width = 4'd8;
            default:    ti.supported = 1'b0;
        endcase
        return ti;
    endfunction

endpackage

@@ design/rdos_step.sv @@
// Next-state and result logic for one directory halfword.
module rdos_step (
    input  logic [15:0]          half_word,
    input  logic                 first,
    input  rdos_pkg::scan_state_t cur,
    input  rdos_pkg::cfg_t        cfg,
    output rdos_pkg::scan_state_t nxt,
    output rdos_pkg::result_t     res
);
    import rdos_pkg::*;

    always_comb
    begin
        scan_state_t st;
        type_info_t  ti;
        logic [31:0] avail;
        logic [31:0] size;
        logic [31:0] bc_new;
        logic [31:0] bl_new;
        logic [32:0] addr;
        logic [33:0] addr_end;
        logic [32:0] range_end;
        logic        hitting;
        logic [32:0] hit;

        st = cur;
        if (first)
        begin
            st = '{phase: PH_PAGE_LO, page_address: '0, block_left: '0,
                   bytes_consumed: '0, final_status: ST_OK, finished: 1'b0};
        end

        avail     = cfg.directory_bytes - st.bytes_consumed;
        size      = {half_word, st.block_left[15:0]};
        ti        = type_info(half_word[15:TypeShift]);
        addr      = {1'b0, st.page_address} + {21'd0, half_word[OffsetBits-1:0]};
        addr_end  = {1'b0, addr} + {30'd0, ti.width};
        range_end = {1'b0, cfg.sample_start} + {1'b0, cfg.sample_length};
        bc_new    = '0;
        bl_new    = '0;
        hitting   = 1'b0;
        hit       = '0;

        if (!st.finished)
        begin
            case (st.phase)
                PH_PAGE_LO:
                begin
                    if (st.bytes_consumed == '0 &&
                        (cfg.directory_address == '0 || cfg.directory_bytes < HeaderBytes))
                    begin
                        st.finished     = 1'b1;
                        st.final_status = (cfg.directory_bytes == '0 &&
                                           cfg.directory_address == '0) ? ST_CLEAN : ST_BAD_DIR;
                    end
                    else if (st.bytes_consumed > cfg.directory_bytes || avail < HeaderBytes)
                    begin
                        st.finished     = 1'b1;
                        st.final_status = ST_TRUNC;
                    end
                    else
                    begin
                        st.page_address = {16'd0, half_word};
                        st.phase        = PH_PAGE_HI;
                    end
                end
                PH_PAGE_HI:
                begin
                    st.page_address = {half_word, st.page_address[15:0]};
                    st.phase        = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    st.block_left = {16'd0, half_word};
                    st.phase      = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    if (size < HeaderBytes || st.bytes_consumed > cfg.directory_bytes ||
                        size > avail || size[0])
                    begin
                        st.finished     = 1'b1;
                        st.final_status = ST_BAD_BLOCK;
                    end
                    else
                    begin
                        bc_new            = st.bytes_consumed + 32'd8;
                        st.block_left     = size - 32'd8;
                        st.bytes_consumed = bc_new;
                        st.phase          = PH_ENTRIES;
                        if (size == 32'd8)
                        begin
                            // empty block ends on its last header halfword
                            st.phase = PH_PAGE_LO;
                            if (bc_new == cfg.directory_bytes)
                            begin
                                st.finished     = 1'b1;
                                st.final_status = ST_CLEAN;
                            end
                        end
                    end
                end
                default:
                begin
                    bl_new            = st.block_left - 32'd2;
                    bc_new            = st.bytes_consumed + 32'd2;
                    st.block_left     = bl_new;
                    st.bytes_consumed = bc_new;
                    if (!ti.supported)
                    begin
                        st.finished     = 1'b1;
                        st.final_status = ST_BAD_TYPE;
                    end
                    else
                    begin
                        if (ti.width != 4'd0 &&
                            {2'b00, cfg.sample_start} < addr_end && addr < range_end)
                        begin
                            hitting         = 1'b1;
                            hit             = addr;
                            st.finished     = 1'b1;
                            st.final_status = ST_OVERLAP;
                        end
                        if (!hitting && bl_new == '0)
                        begin
                            st.phase = PH_PAGE_LO;
                            if (bc_new == cfg.directory_bytes)
                            begin
                                st.finished     = 1'b1;
                                st.final_status = ST_CLEAN;
                            end
                        end
                    end
                end
            endcase
        end

        nxt = st;
        res = '{status: st.final_status, done_res: st.finished, hit_address: hit};
    end

endmodule

@@ design/reloc_directory_overlap_scan.sv @@
// A halfword is held in the input register, then its result is registered for the ports.
// Throughput: one halfword per cycle unless a result is held; state updates with the result.
// A held result stalls the input register, which then stalls the input.
// Reset clears the parser state, configuration registers and valid flags.
// No clearing pass: items are taken from the first cycle after reset.
// Top level: relocation directory overlap scan.
module reloc_directory_overlap_scan (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] half_word,
    input  logic        first,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        done_res,
    output logic [32:0] hit_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rdos_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [15:0] s1_half_reg;
    logic        s1_first_reg;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg;
    scan_state_t state_reg, state_next;
    cfg_t        cfg_reg;
    result_t     step_res;
    logic        advance, accept;

    assign advance  = !res_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign res_valid_next = advance ? s1_valid_reg : res_valid_reg;

    rdos_step u_step (
        .half_word (s1_half_reg),
        .first     (s1_first_reg),
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_PAGE_LO, page_address: '0, block_left: '0,
                               bytes_consumed: '0, final_status: ST_OK, finished: 1'b0};
            cfg_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_valid_reg && advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_SAMPLE_START:  cfg_reg.sample_start      <= cfg_data;
                    REG_SAMPLE_LENGTH: cfg_reg.sample_length     <= cfg_data;
                    REG_DIR_ADDRESS:   cfg_reg.directory_address <= cfg_data;
                    REG_DIR_BYTES:     cfg_reg.directory_bytes   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_half_reg  <= half_word;
            s1_first_reg <= first;
        end
        if (s1_valid_reg && advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid   = res_valid_reg;
    assign status      = res_reg.status;
    assign done_res    = res_reg.done_res;
    assign hit_address = res_reg.hit_address;

endmodule

@@ design/rdos_checker.sv @@
// Port-level checks for the relocation directory overlap scan, bound to the top level.
module rdos_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        done_res,
    input logic [32:0] hit_address
);
    import rdos_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(done_res)
            && $stable(hit_address))
        else $error("result changed while stalled");

    // every non-zero status ends the scan, and only such a status does
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> done_res == (status != ST_OK))
        else $error("done flag disagrees with status");

    // a hit address only comes with an overlap report
    a_hit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_address != 33'd0 |-> status == ST_OVERLAP && done_res)
        else $error("hit address without overlap");

    // the input only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no held result");

endmodule

bind reloc_directory_overlap_scan rdos_checker u_rdos_checker (.*);

@@ tb/reloc_directory_overlap_scan_test.sv @@
// Self-checking testbench for the relocation directory overlap scan, with its own walk predictor.
module reloc_directory_overlap_scan_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdos_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] half_word = 16'h0;
    logic        first = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        done_res;
    logic [32:0] hit_address;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SAMPLE_START;
    logic [31:0] cfg_data = 32'h0;

    reloc_directory_overlap_scan dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .half_word   (half_word),
        .first       (first),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .done_res    (done_res),
        .hit_address (hit_address),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the registers and of the walk
    logic [31:0] cfg_sample_start = 32'h0;
    logic [31:0] cfg_sample_length = 32'h0;
    logic [31:0] cfg_dir_address = 32'h0;
    logic [31:0] cfg_dir_bytes = 32'h0;

    phase_t      walk_phase;
    logic [31:0] walk_page;
    logic [31:0] walk_left;
    logic [31:0] walk_consumed;
    status_t     walk_status;
    logic        walk_done;

    result_t     status_due[$];
    int unsigned walk_items = 0;
    int unsigned sent_items = 0;
    int unsigned errors = 0;
    logic        quiet = 1'b0;

    function automatic void clear_walk();
        walk_phase = PH_PAGE_LO;
        walk_page = '0;
        walk_left = '0;
        walk_consumed = '0;
        walk_status = ST_OK;
        walk_done = 1'b0;
    endfunction

    function automatic void end_walk(input status_t st);
        walk_status = st;
        walk_done = 1'b1;
    endfunction

    function automatic void close_block();
        walk_phase = PH_PAGE_LO;
        if (walk_consumed == cfg_dir_bytes)
            end_walk(ST_CLEAN);
    endfunction

    function automatic result_t walk_halfword(input logic [15:0] hw, input logic start);
        result_t     res;
        logic [31:0] size;
        logic [63:0] addr;
        logic [63:0] span_lo;
        logic [63:0] span_hi;
        int unsigned width;
        logic        known;
        res.hit_address = '0;
        if (start)
            clear_walk();
        if (!walk_done)
        begin
            case (walk_phase)
                PH_PAGE_LO:
                begin
                    if (walk_consumed == 0 && (cfg_dir_address == 0 || cfg_dir_bytes < 8))
                        end_walk((cfg_dir_bytes == 0 && cfg_dir_address == 0) ? ST_CLEAN
                                                                                : ST_BAD_DIR);
                    else if (walk_consumed > cfg_dir_bytes || cfg_dir_bytes - walk_consumed < 8)
                        end_walk(ST_TRUNC);
                    else
                    begin
                        walk_page = {16'h0, hw};
                        walk_phase = PH_PAGE_HI;
                    end
                end
                PH_PAGE_HI:
                begin
                    walk_page[31:16] = hw;
                    walk_phase = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    walk_left = {16'h0, hw};
                    walk_phase = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    size = {hw, walk_left[15:0]};
                    if (size < 8 || walk_consumed > cfg_dir_bytes
                        || size > cfg_dir_bytes - walk_consumed || size[0])
                        end_walk(ST_BAD_BLOCK);
                    else
                    begin
                        walk_left = size - 8;
                        walk_consumed += 8;
                        walk_phase = PH_ENTRIES;
                        if (walk_left == 0)
                            close_block();
                    end
                end
                default:
                begin
                    walk_left -= 2;
                    walk_consumed += 2;
                    known = 1'b1;
                    width = 0;
                    case (hw[15:12])
                        4'd0:       width = 0;
                        4'd1, 4'd2: width = 2;
                        4'd3:       width = 4;
                        4'd10:      width = 8;
                        default:    known = 1'b0;
                    endcase
                    if (!known)
                        end_walk(ST_BAD_TYPE);
                    else
                    begin
                        // 64-bit sums so neither the entry nor the sample range wraps
                        addr = {32'h0, walk_page} + {52'h0, hw[11:0]};
                        span_lo = {32'h0, cfg_sample_start};
                        span_hi = span_lo + {32'h0, cfg_sample_length};
                        if (width != 0 && span_lo < addr + width && addr < span_hi)
                        begin
                            res.hit_address = addr[32:0];
                            end_walk(ST_OVERLAP);
                        end
                        else if (walk_left == 0)
                            close_block();
                    end
                end
            endcase
        end
        res.status = walk_status;
        res.done_res = walk_done;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic push_halfword(input logic [15:0] hw, input logic start);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        half_word <= hw;
        first <= start;
        do @(posedge clk); while (in_stall);
        sent_items++;
        // halfwords that land on a finished walk are not counted
        if (start || !walk_done)
            walk_items++;
        status_due.insert(status_due.size(), walk_halfword(hw, start));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] s, input logic [31:0] l,
                             input logic [31:0] a, input logic [31:0] b);
        reg_index_t  regs[4];
        logic [31:0] vals[4];
        regs = '{REG_SAMPLE_START, REG_SAMPLE_LENGTH, REG_DIR_ADDRESS, REG_DIR_BYTES};
        vals = '{s, l, a, b};
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (regs[i])
                REG_SAMPLE_START:  cfg_sample_start = vals[i];
                REG_SAMPLE_LENGTH: cfg_sample_length = vals[i];
                REG_DIR_ADDRESS:   cfg_dir_address = vals[i];
                default:           cfg_dir_bytes = vals[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic play(input logic [15:0] seq[$]);
        foreach (seq[i])
            push_halfword(seq[i], i == 0);
    endtask

    // one walk of well-formed blocks with random content and the odd corruption
    task automatic run_directory(input logic opening);
        int unsigned rest;
        int unsigned n_entries;
        int unsigned kind;
        logic [31:0] page;
        logic [31:0] size;
        logic [15:0] header[4];
        logic        start;
        logic        over;
        rest = (cfg_dir_bytes <= 600) ? cfg_dir_bytes : $urandom_range(8, 300);
        start = opening;
        over = 1'b0;
        while (rest >= 8 && !over)
        begin
            n_entries = $urandom_range(0, ((rest - 8) / 2 > 12) ? 12 : (rest - 8) / 2);
            if (rest - 8 - 2 * n_entries < 8)
                n_entries = (rest - 8) / 2;
            size = 8 + 2 * n_entries;
            rest -= size;
            if ($urandom_range(0, 1))
                page = $urandom;
            else
                page = {cfg_sample_start[31:12], 12'h0} + (($urandom_range(0, 2) - 1) << 12);
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       size = $urandom_range(0, 7);
                    1:       size = size + 1;
                    2:       size = size + rest + 2 * $urandom_range(1, 20);
                    default: size = $urandom;
                endcase
            end
            header = '{page[15:0], page[31:16], size[15:0], size[31:16]};
            for (int i = 0; i < 4 && !over; i++)
            begin
                push_halfword(header[i], start);
                start = 1'b0;
                over = walk_done;
            end
            for (int i = 0; i < n_entries && !over; i++)
            begin
                case ($urandom_range(0, 4))
                    0:       kind = 0;
                    1:       kind = 1;
                    2:       kind = 2;
                    3:       kind = 3;
                    default: kind = 10;
                endcase
                if ($urandom_range(0, 39) == 0)
                begin
                    kind = $urandom_range(4, 14);
                    if (kind >= 10)
                        kind++;
                end
                push_halfword({kind[3:0], 12'($urandom)}, 1'b0);
                over = walk_done;
            end
        end
        // short tail, too-small directory, or an abandoned long one
        if (!over)
            push_halfword(16'($urandom), start);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_halfword(16'($urandom), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_directory_checks();
        // straight after reset, no first: no directory at all
        push_halfword(16'h1234, 1'b0);
        push_halfword(16'hffff, 1'b0);
        configure(32'h0, 32'h0, 32'h0, 32'd16);
        push_halfword(16'h0001, 1'b1);
        configure(32'h0, 32'h0, 32'h4000, 32'd6);
        push_halfword(16'h8000, 1'b1);
    endtask

    task automatic test_block_walk();
        logic [15:0] seq[$];
        // empty block, then one entry of every supported type
        configure(32'h0, 32'h0, 32'hffff_ffff, 32'd26);
        seq = '{16'h1000, 16'h0000, 16'h0008, 16'h0000,
                16'hffff, 16'hffff, 16'h0012, 16'h0000,
                16'h0abc, 16'h1000, 16'h2fff, 16'h3800, 16'hafff};
        play(seq);
        // overlap at the top of the 33-bit address space
        configure(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd26);
        seq = '{16'hffff, 16'hffff, 16'h000a, 16'h0000, 16'hafff};
        play(seq);
        // odd entry area
        seq = '{16'h0000, 16'h0000, 16'h0009, 16'h0000};
        play(seq);
    endtask

    task automatic test_stale_count();
        logic [15:0] seq[$];
        configure(32'h0, 32'h0, 32'h0000_2000, 32'd100);
        seq = '{16'h3000, 16'h0000, 16'h0008, 16'h0000};
        play(seq);
        // directory shrinks below what the walk has already consumed
        configure(32'h0, 32'h0, 32'h0000_2000, 32'd6);
        push_halfword(16'h5a5a, 1'b0);
    endtask

    task automatic test_random_directories();
        int unsigned phase_end;
        logic [31:0] s;
        logic [31:0] l;
        logic [31:0] a;
        logic [31:0] b;
        for (int ph = 0; sent_items < 1720; ph++)
        begin
            s = $urandom;
            l = $urandom_range(0, 32'h600);
            a = $urandom | 32'h1;
            b = $urandom_range(8, 200) & ~32'h1;
            if ($urandom_range(0, 9) == 0)
                a = 32'h0;
            if ($urandom_range(0, 9) == 0)
                b = $urandom_range(9, 99) | 32'h1;
            if ($urandom_range(0, 19) == 0)
                b = $urandom_range(0, 7);
            case (ph)
                0:
                begin
                    s = 32'h0;
                    l = 32'hffff_ffff;
                end
                1:
                begin
                    s = 32'hffff_ffff;
                    l = 32'h0;
                    a = 32'hffff_ffff;
                    b = 32'hffff_ffff;
                end
                2:
                begin
                    a = 32'h0;
                    b = 32'h0;
                end
                default: ;
            endcase
            configure(s, l, a, b);
            quiet = (ph % 4 == 3);
            phase_end = walk_items + ((ph == 2) ? 20 : 200);
            while (walk_items < phase_end && sent_items < 1720)
                run_directory($urandom_range(0, 9) != 0);
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, status %0d done %0d hit %0h",
                         $time, status, done_res, hit_address);
            end
            else
            begin
                want = status_due.pop_front();
                if (status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                end
                if (done_res !== want.done_res)
                begin
                    errors++;
                    $display("%0t: done_res expected %0d, got %0d",
                             $time, want.done_res, done_res);
                end
                if (hit_address !== want.hit_address)
                begin
                    errors++;
                    $display("%0t: hit_address expected %0h, got %0h",
                             $time, want.hit_address, hit_address);
                end
            end
        end
    end

    initial
    begin
        int unsigned n;
        @(posedge clk);
        forever
        begin
            n = idle_len();
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        clear_walk();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directory_checks();
        test_block_walk();
        test_stale_count();
        test_random_directories();
        wait_idle();
        if (errors == 0)
            $display("PASS reloc_directory_overlap_scan");
        else
            $display("FAIL reloc_directory_overlap_scan");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL reloc_directory_overlap_scan");
        $finish;
    end

endmodule
